[rtl/timed_address_blocklist_core_assert.svh]
// assertion macros used by the checker file
`ifndef TIMED_ADDRESS_BLOCKLIST_CORE_ASSERT_SVH
`define TIMED_ADDRESS_BLOCKLIST_CORE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define TABL_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("blocklist check failed (same cycle)");

// condition in this cycle implies consequence in the next cycle
`define TABL_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("blocklist check failed (next cycle)");

// condition implies consequence a fixed number of cycles later
`define TABL_ASSERT_LATER(label, cond, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##(dly) (cons)) \
    else $error("blocklist check failed (fixed latency)");

`endif

[rtl/tabl_pkg.sv]
package tabl_pkg;

  // number of table entries, one cell each
  localparam int unsigned BLOCK_ENTRIES = 16;

  // cycles from an accepted transaction to its result strobe
  localparam int unsigned RESULT_LATENCY = BLOCK_ENTRIES + 2;

  // operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_DROP   = 2'd1,
    VERDICT_STORED = 2'd2,
    VERDICT_FULL   = 2'd3
  } verdict_t;

  // transaction travelling along the row of cells
  typedef struct packed {
    logic        op;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        addr_is_v6;
    logic [31:0] now_seconds;
    logic [31:0] expiry;
    logic        pending;
    logic        hit;
  } query_t;

endpackage

[rtl/tabl_cell.sv]
module tabl_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_active,
  input  tabl_pkg::query_t q_in,
  output logic             out_active,
  output tabl_pkg::query_t q_out
);
  import tabl_pkg::*;

  logic        entry_valid_r, entry_valid_nxt;
  logic [63:0] entry_addr_high_r;
  logic [63:0] entry_addr_low_r;
  logic        entry_is_v6_r;
  logic [31:0] entry_expiry_r;
  logic        entry_wr;
  logic        addr_match;
  logic        q_active_r;
  query_t      q_r, q_nxt;

  // address and family compare against the held entry
  assign addr_match = (entry_is_v6_r == q_in.addr_is_v6) &&
                      (entry_addr_high_r == q_in.addr_high) &&
                      (entry_addr_low_r == q_in.addr_low);

  // per-cell action on the passing transaction
  always_comb begin
    q_nxt           = q_in;
    entry_valid_nxt = entry_valid_r;
    entry_wr        = 1'b0;
    if (in_active) begin
      if (q_in.op == OP_ADD) begin
        if (q_in.pending && !entry_valid_r) begin
          entry_wr        = 1'b1;
          entry_valid_nxt = 1'b1;
          q_nxt.pending   = 1'b0;
        end
      end else if (entry_valid_r) begin
        if (q_in.now_seconds > entry_expiry_r) begin
          entry_valid_nxt = 1'b0;
        end else if (addr_match) begin
          q_nxt.hit = 1'b1;
        end
      end
    end
  end

  // entry valid bit and forward strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
      q_active_r    <= 1'b0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
      q_active_r    <= in_active;
    end
  end

  // entry payload store
  always_ff @(posedge clk) begin
    if (entry_wr) begin
      entry_addr_high_r <= q_in.addr_high;
      entry_addr_low_r  <= q_in.addr_low;
      entry_is_v6_r     <= q_in.addr_is_v6;
      entry_expiry_r    <= q_in.expiry;
    end
  end

  // hand the transaction to the next cell
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_active = q_active_r;
  assign q_out      = q_r;

endmodule

[rtl/timed_address_blocklist_core.sv]
// Blocked-address table with expiry. A transaction is taken when start is high and busy is
// low; busy then stays high until the result strobe. The transaction walks a row of
// BLOCK_ENTRIES cells, one cell per clock, each cell holding one entry: a check frees
// expired entries and flags a live match, an add lands in the lowest free cell. The result
// appears on out_verdict with out_valid high for one cycle. busy is already low in the strobe
// cycle, so a new transaction can be taken at the same edge at which the result is taken. The
// result cannot be held off: the receiver must take it in the strobe cycle.
module timed_address_blocklist_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic        in_addr_is_v6,
  input  logic [31:0] in_now_seconds,
  input  logic [31:0] in_block_seconds,
  output logic        out_valid,
  output logic [1:0]  out_verdict
);
  import tabl_pkg::*;

  logic     accept;
  logic     busy_r, busy_nxt;
  logic     head_active_r;
  query_t   head_r, head_nxt;
  logic     out_valid_r;
  verdict_t out_verdict_r, out_verdict_nxt;
  logic     chain_active [BLOCK_ENTRIES+1];
  query_t   chain_q      [BLOCK_ENTRIES+1];

  assign accept = start && !busy_r;

  // launch: mask ipv4 addresses and form the expiry time
  always_comb begin
    head_nxt.op          = in_op;
    head_nxt.addr_is_v6  = in_addr_is_v6;
    head_nxt.addr_high   = in_addr_is_v6 ? in_addr_high : 64'd0;
    head_nxt.addr_low    = in_addr_is_v6 ? in_addr_low : {32'd0, in_addr_low[31:0]};
    head_nxt.now_seconds = in_now_seconds;
    head_nxt.expiry      = in_now_seconds + in_block_seconds;
    head_nxt.pending     = (in_op == OP_ADD);
    head_nxt.hit         = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
    end
  end

  assign chain_active[0] = head_active_r;
  assign chain_q[0]      = head_r;

  // row of table cells
  for (genvar i = 0; i < BLOCK_ENTRIES; i++) begin : g_cell
    tabl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_active  (chain_active[i]),
      .q_in       (chain_q[i]),
      .out_active (chain_active[i+1]),
      .q_out      (chain_q[i+1])
    );
  end

  // busy from accept until the transaction leaves the row
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (chain_active[BLOCK_ENTRIES]) begin
      busy_nxt = 1'b0;
    end
  end

  // verdict from the transaction at the end of the row
  always_comb begin
    if (chain_q[BLOCK_ENTRIES].op == OP_ADD) begin
      out_verdict_nxt = chain_q[BLOCK_ENTRIES].pending ? VERDICT_FULL : VERDICT_STORED;
    end else begin
      out_verdict_nxt = chain_q[BLOCK_ENTRIES].hit ? VERDICT_DROP : VERDICT_PASS;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      head_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r        <= busy_nxt;
      head_active_r <= accept;
      out_valid_r   <= chain_active[BLOCK_ENTRIES];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (chain_active[BLOCK_ENTRIES]) begin
      out_verdict_r <= out_verdict_nxt;
    end
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

[rtl/tabl_checker.sv]
`include "timed_address_blocklist_core_assert.svh"

module tabl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_op,
  input logic       out_valid,
  input logic [1:0] out_verdict
);
  import tabl_pkg::*;

  // an accepted transaction raises busy
  `TABL_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

  // a result strobe lasts a single cycle
  `TABL_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

  // a result only closes a busy period
  `TABL_ASSERT_NOW(a_strobe_ends_busy, out_valid, !busy && $past(busy))

  // an add answers stored or full after the fixed latency
  `TABL_ASSERT_LATER(a_add_verdict, start && !busy && (in_op == OP_ADD), RESULT_LATENCY, out_valid && out_verdict[1])

  // a check answers passed or dropped after the fixed latency
  `TABL_ASSERT_LATER(a_check_verdict, start && !busy && (in_op == OP_CHECK), RESULT_LATENCY, out_valid && !out_verdict[1])

endmodule

bind timed_address_blocklist_core tabl_checker u_tabl_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tabl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned POOL_SIZE = 8;

  // one expected verdict per accepted transaction
  typedef struct {
    verdict_t    verdict;
    int unsigned index;
  } verdict_expect_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [63:0] in_addr_high;
  logic [63:0] in_addr_low;
  logic        in_addr_is_v6;
  logic [31:0] in_now_seconds;
  logic [31:0] in_block_seconds;
  logic        out_valid;
  logic [1:0]  out_verdict;

  verdict_expect_t expected_verdicts[$];
  int unsigned     txn_count = 0;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  logic            idle_off = 1'b0;

  // shadow copy of the blocklist table
  logic        shadow_valid [BLOCK_ENTRIES];
  logic [63:0] shadow_high [BLOCK_ENTRIES];
  logic [63:0] shadow_low [BLOCK_ENTRIES];
  logic        shadow_v6 [BLOCK_ENTRIES];
  logic [31:0] shadow_expiry [BLOCK_ENTRIES];

  // recently blocked addresses, reused by the random traffic
  logic [63:0] pool_high [POOL_SIZE];
  logic [63:0] pool_low [POOL_SIZE];
  logic        pool_v6 [POOL_SIZE];
  logic [31:0] pool_expiry [POOL_SIZE];
  int unsigned pool_fill = 0;
  int unsigned pool_wr = 0;

  timed_address_blocklist_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_addr_high     (in_addr_high),
    .in_addr_low      (in_addr_low),
    .in_addr_is_v6    (in_addr_is_v6),
    .in_now_seconds   (in_now_seconds),
    .in_block_seconds (in_block_seconds),
    .out_valid        (out_valid),
    .out_verdict      (out_verdict)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               expected_verdicts.size());
      $display("Verification failed");
      $finish;
    end
  end

  // verdict predictor, updates the shadow table
  function automatic verdict_t blocklist_verdict(input logic op, input logic [63:0] hi_in,
                                                 input logic [63:0] lo_in, input logic v6,
                                                 input logic [31:0] now, input logic [31:0] dur);
    logic [63:0] hi;
    logic [63:0] lo;
    logic        placed;
    verdict_t    v;
    hi = v6 ? hi_in : 64'd0;
    lo = v6 ? lo_in : {32'd0, lo_in[31:0]};
    placed = 1'b0;
    if (op == OP_ADD) begin
      v = VERDICT_FULL;
      // lowest free slot takes the new block
      for (int i = 0; i < BLOCK_ENTRIES; i++) begin
        if (!placed && !shadow_valid[i]) begin
          shadow_valid[i] = 1'b1;
          shadow_high[i] = hi;
          shadow_low[i] = lo;
          shadow_v6[i] = v6;
          shadow_expiry[i] = now + dur;
          placed = 1'b1;
          v = VERDICT_STORED;
        end
      end
    end else begin
      v = VERDICT_PASS;
      // free expired entries, drop on a live match
      for (int i = 0; i < BLOCK_ENTRIES; i++) begin
        if (shadow_valid[i]) begin
          if (now > shadow_expiry[i]) begin
            shadow_valid[i] = 1'b0;
          end else if (shadow_v6[i] == v6 && shadow_high[i] == hi && shadow_low[i] == lo) begin
            v = VERDICT_DROP;
          end
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  // send one transaction, optionally after an idle gap, and record its verdict
  task automatic send_txn(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                          input logic v6, input logic [31:0] now, input logic [31:0] dur);
    int unsigned gap;
    verdict_expect_t exp_item;
    if (!idle_off && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      gap = $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end
    in_op <= op;
    in_addr_high <= hi;
    in_addr_low <= lo;
    in_addr_is_v6 <= v6;
    in_now_seconds <= now;
    in_block_seconds <= dur;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    exp_item.verdict = blocklist_verdict(op, hi, lo, v6, now, dur);
    exp_item.index = txn_count;
    expected_verdicts.push_back(exp_item);
    txn_count++;
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_expect_t exp_item;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result strobe with no transaction waiting, actual verdict %0d",
                 $time, out_verdict);
        error_count++;
      end else begin
        exp_item = expected_verdicts.pop_front();
        if (out_verdict !== exp_item.verdict) begin
          $display("%0t: transaction %0d verdict mismatch, expected %0d actual %0d",
                   $time, exp_item.index, exp_item.verdict, out_verdict);
          error_count++;
        end
      end
    end
  end

  // ipv4 ignores upper bits, family must match
  task automatic test_match_rules();
    send_txn(OP_ADD, 64'hDEAD_BEEF_0000_0001, 64'h1234_5678_C0A8_0001, 1'b0, 32'd0,
             32'h0000_1000);
    send_txn(OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_0000_C0A8_0001, 1'b0, 32'd0, 32'd0);
    send_txn(OP_CHECK, 64'd0, 64'h0000_0000_C0A8_0001, 1'b1, 32'd0, 32'd0);
    send_txn(OP_CHECK, 64'd0, 64'h0000_0000_C0A8_0002, 1'b0, 32'd0, 32'd0);
    drain_results();
  endtask

  // entry live at its expiry, freed one second later, expiry wraps
  task automatic test_expiry_rules();
    send_txn(OP_ADD, 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0042, 1'b1, 32'd100, 32'd50);
    send_txn(OP_CHECK, 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0042, 1'b1, 32'd150, 32'd0);
    send_txn(OP_CHECK, 64'h2001_0DB8_0000_0000, 64'h0000_0000_0000_0042, 1'b1, 32'd151, 32'd0);
    send_txn(OP_ADD, '1, '1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_txn(OP_CHECK, '1, '1, 1'b1, 32'hFFFF_FFFE, 32'd0);
    drain_results();
  endtask

  // duplicate adds fill the table until one is refused, then one check frees all
  task automatic test_full_table();
    for (int i = 0; i < BLOCK_ENTRIES; i++) begin
      send_txn(OP_ADD, '1, '1, 1'b1, 32'h0000_2000, 32'(i));
    end
    send_txn(OP_CHECK, '1, '1, 1'b1, 32'hFFFF_FFFF, 32'd0);
    drain_results();
  endtask

  // mixed adds and checks around a moving clock
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned add_pct;
    int unsigned sel;
    logic        op;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] now;
    logic [31:0] dur;
    logic [31:0] clock_now;
    add_pct = 50;
    clock_now = $urandom;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 20;
          1: add_pct = 50;
          default: add_pct = 80;
        endcase
      end
      idle_off = (k >= 200 && k < 350);
      if (k == n_items / 2) drain_results();

      // time mostly advances, with an occasional jump
      if ($urandom_range(0, 99) < 4) clock_now = $urandom;
      else clock_now = clock_now + 32'($urandom_range(0, 30));
      now = clock_now;
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_CHECK;

      // reuse a blocked address or pick a fresh one
      if (pool_fill != 0 && $urandom_range(0, 99) < 65) begin
        sel = $urandom_range(0, pool_fill - 1);
        hi = pool_high[sel];
        lo = pool_low[sel];
        v6 = pool_v6[sel];
        if (!v6) begin
          hi = random64();
          lo[63:32] = $urandom;
        end
        if ($urandom_range(0, 99) < 8) v6 = ~v6;
        if (op == OP_CHECK && $urandom_range(0, 99) < 30)
          now = pool_expiry[sel] + 32'($urandom_range(0, 2)) - 32'd1;
      end else begin
        v6 = 1'($urandom_range(0, 1));
        hi = random64();
        lo = random64();
        case ($urandom_range(0, 9))
          0: begin
            hi = '0;
            lo = '0;
          end
          1: begin
            hi = '1;
            lo = '1;
          end
          default: ;
        endcase
      end

      case ($urandom_range(0, 19))
        0: dur = 32'd0;
        1: dur = 32'hFFFF_FFFF;
        2, 3: dur = $urandom;
        default: dur = 32'($urandom_range(0, 300));
      endcase

      if (op == OP_ADD) begin
        pool_high[pool_wr] = hi;
        pool_low[pool_wr] = lo;
        pool_v6[pool_wr] = v6;
        pool_expiry[pool_wr] = now + dur;
        pool_wr = (pool_wr + 1) % POOL_SIZE;
        if (pool_fill < POOL_SIZE) pool_fill++;
      end
      send_txn(op, hi, lo, v6, now, dur);
    end
    idle_off = 1'b0;
    drain_results();
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < BLOCK_ENTRIES; i++) shadow_valid[i] = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_CHECK;
    in_addr_high <= '0;
    in_addr_low <= '0;
    in_addr_is_v6 <= 1'b0;
    in_now_seconds <= '0;
    in_block_seconds <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_match_rules();
    test_expiry_rules();
    test_full_table();
    test_random_traffic(RANDOM_ITEMS);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
